/* rtl/gillespie_cell_propensity_macros.svh */
// assertion macros for the propensity block
`ifndef GILLESPIE_CELL_PROPENSITY_MACROS_SVH
`define GILLESPIE_CELL_PROPENSITY_MACROS_SVH
`ifndef SYNTHESIS
`define GCP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define GCP_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define GCP_ASSERT(label, clk, rst, prop)
`define GCP_ASSERT_NR(label, clk, prop)
`endif
`endif

/* rtl/gcp_pkg.sv */
// shared types and constants for the propensity block
package gcp_pkg;
   localparam int POP_BITS   = 16;
   localparam int NUM_EVENTS = 12;
   localparam int EV_BITS    = 4;
   localparam int COEF_BITS  = 32;
   localparam int PROP_BITS  = 48;
   localparam int CELL_BITS  = 52;
   localparam int TOT_BITS   = 62;
   localparam int QDEPTH     = 2;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_CELL = 1'b1;

   localparam logic [EV_BITS-1:0] EV_R3   = 4'd3;
   localparam logic [EV_BITS-1:0] EV_R4   = 4'd4;
   localparam logic [EV_BITS-1:0] EV_R9   = 4'd9;
   localparam logic [EV_BITS-1:0] EV_LAST = 4'd11;

   localparam logic [0:0] CSR_WPN = 1'b0;
   localparam logic [0:0] CSR_NC  = 1'b1;

   typedef struct packed {
      logic                first;
      logic [POP_BITS-1:0] w;
      logic [POP_BITS-1:0] q;
      logic [POP_BITS-1:0] f;
      logic [POP_BITS-1:0] p;
   } cell_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV3, ST_DIV4, ST_DIV9, ST_EMIT
   } state_type;
endpackage

/* rtl/gcp_front.sv */
// front end: coefficient loads and cell queue
module gcp_front (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_func,
   input  logic [gcp_pkg::EV_BITS-1:0]               req_coef_index,
   input  logic [gcp_pkg::COEF_BITS-1:0]             req_coef_value,
   input  gcp_pkg::cell_type                         req_cell,
   output logic                                      q_valid,
   input  logic                                      q_pop,
   output gcp_pkg::cell_type                         q_cell,
   input  logic                                      back_idle,
   output logic [gcp_pkg::NUM_EVENTS-1:0][gcp_pkg::COEF_BITS-1:0] coef
);
   logic [gcp_pkg::NUM_EVENTS-1:0][gcp_pkg::COEF_BITS-1:0] coef_ff;
   gcp_pkg::cell_type q_mem [gcp_pkg::QDEPTH];
   logic [0:0] wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   // a load waits until every earlier cell has been fully worked off
   assign req_ready = (req_func == gcp_pkg::FUNC_LOAD) ? ((cnt_ff == 2'd0) && back_idle)
                                                      : (cnt_ff != 2'(gcp_pkg::QDEPTH));
   assign push      = req_valid && req_ready && (req_func == gcp_pkg::FUNC_CELL);
   assign q_valid   = cnt_ff != 2'd0;
   assign q_cell    = q_mem[rp_ff];
   assign coef      = coef_ff;
   assign cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
         wp_ff   <= '0;
         rp_ff   <= '0;
         cnt_ff  <= '0;
      end else begin
         if (req_valid && req_ready && req_func == gcp_pkg::FUNC_LOAD &&
             req_coef_index < 4'(gcp_pkg::NUM_EVENTS))
            coef_ff[req_coef_index] <= req_coef_value;
         if (push) wp_ff <= wp_ff + 1'b1;
         if (q_pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_mem[wp_ff] <= req_cell;
   end
endmodule

/* rtl/gcp_div.sv */
// restoring divider, one quotient bit per cycle, 64 by 32 bits
module gcp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff;
   logic [6:0]  n_ff, n_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] sh;

   assign done     = done_ff;
   assign quotient = q_ff;

   always_comb begin
      q_in = q_ff; r_in = r_ff; n_in = n_ff;
      busy_in = busy_ff; done_in = 1'b0;
      sh = {r_ff[31:0], q_ff[63]};
      if (start) begin
         q_in = dividend; r_in = '0; n_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[62:0], 1'b0};
         end
         n_in = n_ff - 7'd1;
         if (n_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; n_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; n_ff <= n_in;
      end
      q_ff <= q_in; r_ff <= r_in;
      if (start) d_ff <= divisor;
   end
endmodule

/* rtl/gcp_back.sv */
// back end: logistic divides, then one propensity per cycle with sums while the result side accepts
module gcp_back (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [15:0]                               wpn,
   input  logic [15:0]                               ncap,
   input  logic [gcp_pkg::NUM_EVENTS-1:0][gcp_pkg::COEF_BITS-1:0] coef,
   input  logic                                      q_valid,
   output logic                                      q_pop,
   input  gcp_pkg::cell_type                         q_cell,
   output logic                                      idle,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [gcp_pkg::EV_BITS-1:0]               rsp_event_index,
   output logic [gcp_pkg::PROP_BITS-1:0]             rsp_propensity,
   output logic [gcp_pkg::CELL_BITS-1:0]             rsp_cell_rate,
   output logic [gcp_pkg::TOT_BITS-1:0]              rsp_total_rate,
   output logic [gcp_pkg::CELL_BITS-1:0]             rsp_max_cell_rate,
   output logic                                      rsp_total_is_zero,
   output logic                                      rsp_last_of_cell
);
   localparam logic [47:0] PMAX = {48{1'b1}};
   localparam logic [61:0] TMAX = {62{1'b1}};
   localparam logic [3:0] EV_LAST = gcp_pkg::EV_LAST;
   localparam logic [3:0] EV_R3 = gcp_pkg::EV_R3;
   localparam logic [3:0] EV_R4 = gcp_pkg::EV_R4;
   localparam logic [3:0] EV_R9 = gcp_pkg::EV_R9;

   gcp_pkg::state_type st_ff, st_in;
   gcp_pkg::cell_type  c_ff;
   logic [31:0] kw_ff, kq;
   logic [31:0] r3_ff, r4_ff;
   logic [47:0] r9_ff;
   logic [3:0]  k_ff;
   logic [51:0] cell_ff, cell_next, max_ff, max_new;
   logic [61:0] tot_ff, tot_new, tot_base;
   logic [51:0] mx_base;
   logic        div_start, div_done;
   logic [63:0] div_num, div_q;
   logic [31:0] div_den;
   logic [47:0] a;
   logic [15:0] b;
   logic [63:0] prod;
   logic [47:0] prop;
   logic        ov_valid_ff, step;
   logic [62:0] tsum;
   logic [15:0] wpn1, nc1;
   // r9 lands when the last divide finishes inside emit
   logic        r9_ok_ff;

   gcp_div u_div (.clock, .reset, .start(div_start), .dividend(div_num),
                  .divisor(div_den), .done(div_done), .quotient(div_q));

   assign wpn1 = (wpn == 16'd0) ? 16'd1 : wpn;
   assign nc1  = (ncap == 16'd0) ? 16'd1 : ncap;
   assign kq   = {16'd0, nc1};
   assign idle = (st_ff == gcp_pkg::ST_IDLE);

   // multiplier operands per event
   always_comb begin
      unique case (k_ff)
         4'd0, 4'd2: begin a = 48'(coef[k_ff]); b = c_ff.w; end
         4'd1, 4'd7: begin a = 48'(coef[k_ff]); b = 16'd1; end
         4'd3:       begin a = 48'(r3_ff); b = c_ff.q; end
         4'd4:       begin a = 48'(r4_ff); b = c_ff.w; end
         4'd5:       begin a = 48'(coef[k_ff]); b = c_ff.q; end
         4'd9:       begin a = r9_ff; b = c_ff.f; end
         4'd6, 4'd8: begin a = 48'(coef[k_ff]); b = c_ff.f; end
         default:    begin a = 48'(coef[k_ff]); b = c_ff.p; end
      endcase
      prod = 64'(a) * 64'(b);
      prop = (prod[63:48] != 16'd0) ? PMAX : prod[47:0];
   end

   assign step      = (st_ff == gcp_pkg::ST_EMIT) && (!ov_valid_ff || rsp_ready);
   assign cell_next = cell_ff + 52'(prop);
   assign tsum      = {1'b0, tot_ff} + {11'd0, cell_next};
   assign tot_new   = tsum[62] ? TMAX : tsum[61:0];
   assign max_new   = (cell_next > max_ff) ? cell_next : max_ff;
   assign tot_base  = tot_ff;
   assign mx_base   = max_ff;

   always_comb begin
      st_in = st_ff; q_pop = 1'b0; div_start = 1'b0;
      div_num = '0; div_den = kw_ff;
      unique case (st_ff)
         gcp_pkg::ST_IDLE: if (q_valid) begin
            q_pop = 1'b1; st_in = gcp_pkg::ST_DIV3;
         end
         gcp_pkg::ST_DIV3: begin
            div_start = 1'b1;
            div_num = (32'(c_ff.w) >= kw_ff) ? 64'd0
                    : 64'(coef[EV_R3]) * 64'(kw_ff - 32'(c_ff.w));
            st_in = gcp_pkg::ST_DIV4;
         end
         gcp_pkg::ST_DIV4: if (div_done) begin
            div_start = 1'b1; div_den = kq;
            div_num = (32'(c_ff.q) >= kq) ? 64'd0
                    : 64'(coef[EV_R4]) * 64'(kq - 32'(c_ff.q));
            st_in = gcp_pkg::ST_DIV9;
         end
         gcp_pkg::ST_DIV9: if (div_done) begin
            div_start = 1'b1;
            div_num = 64'(coef[EV_R9]) * 64'(c_ff.w);
            st_in = gcp_pkg::ST_EMIT;
         end
         gcp_pkg::ST_EMIT: if (step && k_ff == EV_LAST) st_in = gcp_pkg::ST_IDLE;
         default: st_in = gcp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= gcp_pkg::ST_IDLE;
         ov_valid_ff <= 1'b0;
         tot_ff <= '0; max_ff <= '0;
         r9_ok_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_valid_ff <= (step && r9_ok_ff) || (ov_valid_ff && !rsp_ready);
         if (st_ff == gcp_pkg::ST_IDLE && q_valid) begin
            if (q_cell.first) begin
               tot_ff <= '0; max_ff <= '0;
            end
         end
         if (div_done && st_ff == gcp_pkg::ST_EMIT) r9_ok_ff <= 1'b1;
         if (step && r9_ok_ff) begin
            if (k_ff == EV_LAST) begin
               tot_ff <= tot_new; max_ff <= max_new; r9_ok_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == gcp_pkg::ST_IDLE) begin
         c_ff <= q_cell;
         k_ff <= '0;
         cell_ff <= '0;
      end
      kw_ff <= 32'(wpn1) * 32'(nc1);
      if (div_done && st_ff == gcp_pkg::ST_DIV4) r3_ff <= div_q[31:0];
      if (div_done && st_ff == gcp_pkg::ST_DIV9) r4_ff <= div_q[31:0];
      if (div_done && st_ff == gcp_pkg::ST_EMIT) r9_ff <= div_q[47:0];
      if (step && r9_ok_ff) begin
         k_ff <= k_ff + 4'd1;
         cell_ff <= cell_next;
         rsp_event_index <= k_ff;
         rsp_propensity  <= prop;
         rsp_cell_rate   <= cell_next;
         rsp_last_of_cell <= (k_ff == EV_LAST);
         rsp_total_rate  <= (k_ff == EV_LAST) ? tot_new : tot_base;
         rsp_max_cell_rate <= (k_ff == EV_LAST) ? max_new : mx_base;
         rsp_total_is_zero <= ((k_ff == EV_LAST) ? tot_new : tot_base) == 62'd0;
      end
   end

   assign rsp_valid = ov_valid_ff;
endmodule

/* rtl/gillespie_cell_propensity.sv */
// propensity engine top level: front queue, divider back end
// a cell is worked off in order: a pop, three serial 64-bit divides, then twelve
// results at one per cycle when the result side never stalls
// a coefficient load waits until all earlier cells are done
// synchronous active-high reset clears coefficients, totals, queue, capacities to one
`include "gillespie_cell_propensity_macros.svh"
module gillespie_cell_propensity (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [3:0]  req_coef_index,
   input  logic [31:0] req_coef_value,
   input  logic        req_first_cell,
   input  logic [15:0] req_n_workers,
   input  logic [15:0] req_n_queens,
   input  logic [15:0] req_n_flies,
   input  logic [15:0] req_n_parasitized,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_event_index,
   output logic [47:0] rsp_propensity,
   output logic [51:0] rsp_cell_rate,
   output logic [61:0] rsp_total_rate,
   output logic [51:0] rsp_max_cell_rate,
   output logic        rsp_total_is_zero,
   output logic        rsp_last_of_cell,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);
   logic [15:0] wpn_ff, nc_ff;
   gcp_pkg::cell_type req_cell, q_cell;
   logic q_valid, q_pop, back_idle;
   logic [gcp_pkg::NUM_EVENTS-1:0][gcp_pkg::COEF_BITS-1:0] coef;

   assign req_cell = '{first: req_first_cell, w: req_n_workers, q: req_n_queens,
                       f: req_n_flies, p: req_n_parasitized};

   always_ff @(posedge clock) begin
      if (reset) begin
         wpn_ff <= 16'd1; nc_ff <= 16'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            gcp_pkg::CSR_WPN: wpn_ff <= csr_data;
            gcp_pkg::CSR_NC:  nc_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   gcp_front u_front (.clock, .reset, .req_valid, .req_ready, .req_func,
      .req_coef_index, .req_coef_value, .req_cell, .q_valid, .q_pop, .q_cell,
      .back_idle, .coef);

   gcp_back u_back (.clock, .reset, .wpn(wpn_ff), .ncap(nc_ff), .coef, .q_valid,
      .q_pop, .q_cell, .idle(back_idle), .rsp_valid, .rsp_ready, .rsp_event_index,
      .rsp_propensity, .rsp_cell_rate, .rsp_total_rate, .rsp_max_cell_rate,
      .rsp_total_is_zero, .rsp_last_of_cell);

   `GCP_ASSERT(a_zero_flag, clock, reset, rsp_valid |-> (rsp_total_is_zero == (rsp_total_rate == 62'd0)))
   `GCP_ASSERT(a_last_idx, clock, reset, rsp_valid && rsp_last_of_cell |-> rsp_event_index == gcp_pkg::EV_LAST)
   `GCP_ASSERT(a_prop_le_cell, clock, reset, rsp_valid |-> 52'(rsp_propensity) <= rsp_cell_rate)
endmodule

/* tb/sv/tb_gillespie_cell_propensity.sv */
// self-checking testbench for the cell propensity engine
module tb_gillespie_cell_propensity;

   localparam logic [63:0] PROP_SAT  = (64'd1 << 48) - 1;
   localparam logic [63:0] TOTAL_SAT = (64'd1 << 62) - 1;
   localparam int          DRAIN     = 250;

   typedef struct {
      logic [3:0]  ev;
      logic [47:0] prop;
      logic [51:0] csum;
      logic [61:0] tot;
      logic [51:0] mx;
      logic        tz;
      logic        last;
   } rate_result_type;

   typedef struct {
      logic        func;
      logic [3:0]  idx;
      logic [31:0] val;
      logic        first;
      logic [15:0] w, q, f, p;
      logic        all_zero;   // typed expectation: rates and sums zero, total flagged zero
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = gcp_pkg::FUNC_LOAD;
   logic [3:0]  req_coef_index = '0;
   logic [31:0] req_coef_value = '0;
   logic        req_first_cell = 1'b0;
   logic [15:0] req_n_workers = '0, req_n_queens = '0, req_n_flies = '0;
   logic [15:0] req_n_parasitized = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_event_index;
   logic [47:0] rsp_propensity;
   logic [51:0] rsp_cell_rate;
   logic [61:0] rsp_total_rate;
   logic [51:0] rsp_max_cell_rate;
   logic        rsp_total_is_zero;
   logic        rsp_last_of_cell;
   logic        csr_write = 1'b0;
   logic [0:0]  csr_index = gcp_pkg::CSR_WPN;
   logic [15:0] csr_data = '0;

   gillespie_cell_propensity dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [31:0] coef_mem [gcp_pkg::NUM_EVENTS];
   logic [63:0] run_total, run_max;
   logic [15:0] wpn_reg, ncap_reg;
   rate_result_type expected_rates [$];
   logic        row_all_zero = 1'b0;
   logic        calm = 1'b0;
   int          mismatches = 0, cells_sent = 0, loads_sent = 0, results_seen = 0;

   function automatic logic [63:0] sat48(input logic [63:0] x);
      return (x > PROP_SAT) ? PROP_SAT : x;
   endfunction

   task automatic predict_cell(input logic first, input logic [15:0] w, q, f, p,
                               input logic typed_zero);
      logic [63:0] kw, kq, r, acc;
      logic [63:0] pr [gcp_pkg::NUM_EVENTS];
      rate_result_type e;
      if (first) begin
         run_total = 0;
         run_max = 0;
      end
      kq = (ncap_reg == 0) ? 64'd1 : 64'(ncap_reg);
      kw = ((wpn_reg == 0) ? 64'd1 : 64'(wpn_reg)) * kq;
      pr[0]  = sat48(coef_mem[0] * 64'(w));
      pr[1]  = 64'(coef_mem[1]);
      pr[2]  = sat48(coef_mem[2] * 64'(w));
      r      = (64'(w) >= kw) ? 64'd0 : (64'(coef_mem[3]) * (kw - 64'(w))) / kw;
      pr[3]  = sat48(r * 64'(q));
      r      = (64'(q) >= kq) ? 64'd0 : (64'(coef_mem[4]) * (kq - 64'(q))) / kq;
      pr[4]  = sat48(r * 64'(w));
      pr[5]  = sat48(coef_mem[5] * 64'(q));
      pr[6]  = sat48(coef_mem[6] * 64'(f));
      pr[7]  = 64'(coef_mem[7]);
      pr[8]  = sat48(coef_mem[8] * 64'(f));
      r      = (64'(coef_mem[9]) * 64'(w)) / kw;
      pr[9]  = sat48(r * 64'(f));
      pr[10] = sat48(coef_mem[10] * 64'(p));
      pr[11] = sat48(coef_mem[11] * 64'(p));
      acc = 0;
      for (int k = 0; k < gcp_pkg::NUM_EVENTS; k++) begin
         acc += pr[k];
         if (k == gcp_pkg::NUM_EVENTS - 1) begin
            run_total = (acc > TOTAL_SAT - run_total) ? TOTAL_SAT : run_total + acc;
            if (acc > run_max) run_max = acc;
         end
         e.ev   = 4'(k);
         e.prop = pr[k][47:0];
         e.csum = acc[51:0];
         e.tot  = run_total[61:0];
         e.mx   = run_max[51:0];
         e.tz   = (run_total == 0);
         e.last = (4'(k) == gcp_pkg::EV_LAST);
         if (typed_zero) begin
            e.prop = '0; e.csum = '0; e.tot = '0; e.mx = '0; e.tz = 1'b1;
         end
         expected_rates.push_back(e);
      end
   endtask

   // accepted requests feed the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         if (req_func == gcp_pkg::FUNC_LOAD) begin
            if (req_coef_index < gcp_pkg::NUM_EVENTS)
               coef_mem[req_coef_index] = req_coef_value;
            loads_sent++;
         end else begin
            predict_cell(req_first_cell, req_n_workers, req_n_queens, req_n_flies,
                         req_n_parasitized, row_all_zero);
            cells_sent++;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      rate_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_rates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction, event %0d",
                                           rsp_event_index);
         end else begin
            e = expected_rates.pop_front();
            if (rsp_event_index !== e.ev || rsp_propensity !== e.prop ||
                rsp_cell_rate !== e.csum || rsp_total_rate !== e.tot ||
                rsp_max_cell_rate !== e.mx || rsp_total_is_zero !== e.tz ||
                rsp_last_of_cell !== e.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp ev=%0d prop=%h cell=%h tot=%h max=%h tz=%b last=%b",
                           e.ev, e.prop, e.csum, e.tot, e.mx, e.tz, e.last);
                  $display("         got ev=%0d prop=%h cell=%h tot=%h max=%h tz=%b last=%b",
                           rsp_event_index, rsp_propensity, rsp_cell_rate, rsp_total_rate,
                           rsp_max_cell_rate, rsp_total_is_zero, rsp_last_of_cell);
               end
            end
         end
      end
   end

   always @(negedge clock)
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 31);

   task automatic send(input stim_row_type s);
      if (!calm && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= s.func;
      req_coef_index    <= s.idx;
      req_coef_value    <= s.val;
      req_first_cell    <= s.first;
      req_n_workers     <= s.w;
      req_n_queens      <= s.q;
      req_n_flies       <= s.f;
      req_n_parasitized <= s.p;
      row_all_zero      <= s.all_zero;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic set_capacity(input logic [15:0] wpn, input logic [15:0] ncap);
      req_valid <= 1'b0;
      @(negedge clock);
      wait (expected_rates.size() == 0);
      repeat (DRAIN) @(negedge clock);
      csr_write <= 1'b1; csr_index <= gcp_pkg::CSR_WPN; csr_data <= wpn;
      @(negedge clock);
      csr_index <= gcp_pkg::CSR_NC; csr_data <= ncap;
      @(negedge clock);
      csr_write <= 1'b0;
      wpn_reg  = wpn;
      ncap_reg = ncap;
   endtask

   function automatic logic [15:0] pick_count(input logic [15:0] around);
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(int'(around) + 3));
      endcase
   endfunction

   task automatic random_items(input int n, input logic [15:0] around);
      stim_row_type s;
      for (int i = 0; i < n; i++) begin
         calm = (i >= n / 2 && i < n / 2 + 12);
         s.func = ($urandom_range(99) < 25) ? gcp_pkg::FUNC_LOAD : gcp_pkg::FUNC_CELL;
         s.idx  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 12))
                                           : 4'($urandom_range(11));
         case ($urandom_range(4))
            0: s.val = 32'hFFFF_FFFF;
            1: s.val = 32'($urandom_range(32'h0004_0000));
            default: s.val = $urandom;
         endcase
         s.first = ($urandom_range(99) < 15);
         s.w = pick_count(around);
         s.q = pick_count(16'($urandom_range(8)));
         s.f = pick_count(around);
         s.p = pick_count(around);
         s.all_zero = 1'b0;
         send(s);
      end
      calm = 1'b0;
   endtask

   stim_row_type directed [] = '{
      '{gcp_pkg::FUNC_CELL, 4'd0,  32'h0,         1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1},
      '{gcp_pkg::FUNC_LOAD, 4'd0,  32'hFFFF_FFFF, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_LOAD, 4'd1,  32'h0001_0000, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_LOAD, 4'd2,  32'h0000_0001, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_LOAD, 4'd3,  32'h0002_0000, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_LOAD, 4'd4,  32'h0003_0000, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_LOAD, 4'd5,  32'hFFFF_FFFF, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_LOAD, 4'd6,  32'h0000_8000, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_LOAD, 4'd7,  32'hFFFF_FFFF, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_LOAD, 4'd8,  32'h1234_5678, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_LOAD, 4'd9,  32'h0005_0000, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_LOAD, 4'd10, 32'hFFFF_FFFF, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_LOAD, 4'd11, 32'h0000_0001, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      // out-of-range indexes must leave the table alone
      '{gcp_pkg::FUNC_LOAD, 4'd12, 32'hDEAD_BEEF, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_LOAD, 4'd15, 32'hFFFF_FFFF, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_CELL, 4'd0,  32'h0,         1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_CELL, 4'd0,  32'h0,         1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0},
      '{gcp_pkg::FUNC_CELL, 4'd0,  32'h0,         1'b0, 16'h0, 16'h0, 16'h1, 16'hFFFF, 1'b0},
      '{gcp_pkg::FUNC_CELL, 4'd0,  32'h0,         1'b0, 16'h1, 16'hFFFF, 16'h0, 16'h1, 1'b0},
      '{gcp_pkg::FUNC_CELL, 4'd0,  32'h0,         1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0},
      '{gcp_pkg::FUNC_CELL, 4'd0,  32'h0,         1'b0, 16'h1234, 16'h0003, 16'h00FF, 16'h8000, 1'b0}
   };

   initial begin
      stim_row_type s;
      for (int k = 0; k < gcp_pkg::NUM_EVENTS; k++) coef_mem[k] = '0;
      run_total = 0; run_max = 0; wpn_reg = 16'd1; ncap_reg = 16'd1;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed[i]) send(directed[i]);

      set_capacity(16'd0, 16'd0);         // zero capacity reads as one
      random_items(30, 16'd2);
      set_capacity(16'hFFFF, 16'hFFFF);
      random_items(30, 16'd300);
      set_capacity(16'd20, 16'd3);
      random_items(35, 16'd60);
      set_capacity(16'($urandom_range(65535, 1)), 16'($urandom_range(16, 1)));
      random_items(35, 16'd100);

      // maxed coefficients and worker, fly and parasitized counts drive large propensities; event 9 reaches its ceiling
      set_capacity(16'd1, 16'd1);
      calm = 1'b1;
      for (int k = 0; k < gcp_pkg::NUM_EVENTS; k++) begin
         s = '{gcp_pkg::FUNC_LOAD, 4'(k), 32'hFFFF_FFFF, 1'b0, 16'h0, 16'h0, 16'h0,
               16'h0, 1'b0};
         send(s);
      end
      for (int n = 0; n < 20; n++) begin
         s = '{gcp_pkg::FUNC_CELL, 4'd0, 32'h0, (n == 0), 16'hFFFF, 16'h0, 16'hFFFF,
               16'hFFFF, 1'b0};
         send(s);
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      wait (expected_rates.size() == 0);
      repeat (DRAIN) @(posedge clock);
      $display("covered %0d coefficient loads and %0d cells, %0d results checked",
               loads_sent, cells_sent, results_seen);
      $display("capacities swept from zero to full scale, propensities driven to saturation");
      if (mismatches == 0 && expected_rates.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("mismatch count %0d", mismatches);
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d results outstanding", expected_rates.size());
      $display("FAILED: results differ");
      $finish;
   end
endmodule
